/* hw/rtl/mcpd_pkg.sv */
// shared constants for the multichannel phase-cut pwm dimmer
// no dependencies; used by multichannel_phase_cut_pwm_dimmer

package mcpd_pkg;

    localparam int CHANNELS_DEFAULT = 2;
    localparam int CHANNELS_MAX     = 16;

    localparam int FUNC_W   = 1;
    localparam int CHAN_W   = 8;
    localparam int BRIGHT_W = 8;
    localparam int MASK_W   = 2;
    localparam int LAMP_W   = 2;
    localparam int DELAY_W  = 10;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    localparam logic [DELAY_W-1:0]  PERIOD_END  = 10'd512;
    localparam logic [BRIGHT_W-1:0] FULL_BRIGHT = 8'd255;
    localparam logic [BRIGHT_W-1:0] ZERO_BRIGHT = 8'd0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK = 1'b0,
        FUNC_SET  = 1'b1
    } func_t;

    typedef struct packed {
        logic [MASK_W-1:0]   enable_mask;
        logic [BRIGHT_W-1:0] brightness;
        logic [CHAN_W-1:0]   channel;
        func_t               func;
    } item_t;

endpackage

/* hw/rtl/multichannel_phase_cut_pwm_dimmer.sv */
// multichannel phase-cut pwm dimmer, top level
// uses mcpd_pkg for widths, constants and the function code type
// two register stages: input register, then result register; a result waits while m_tready is low
// throughput: one item per cycle unless m_tready stalls; state update and compares are combinational
// reset: synchronous active-low aresetn clears counter, flags, lamps and m_tvalid, delays to 512

module multichannel_phase_cut_pwm_dimmer #(
    parameter int CHANNELS = mcpd_pkg::CHANNELS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // channel[7:0], brightness[15:8], enable_mask[17:16], zero fill
    input  logic [mcpd_pkg::S_DATA_W-1:0] s_tdata,
    // func[0]
    input  logic [mcpd_pkg::FUNC_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // lamp_outputs[1:0], full_on_flag[2], zero fill
    output logic [mcpd_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int DW = mcpd_pkg::DELAY_W;

    logic                  in_valid_reg;
    mcpd_pkg::item_t       in_item_reg;
    logic                  out_valid_reg;
    logic [mcpd_pkg::LAMP_W-1:0] out_lamps_reg;
    logic                  out_flag_reg;

    logic [DW-1:0]         count_reg, count_next;
    logic [DW-1:0]         pending_reg [CHANNELS];
    logic [DW-1:0]         pending_next [CHANNELS];
    logic [DW-1:0]         latched_reg [CHANNELS];
    logic [DW-1:0]         latched_next [CHANNELS];
    logic [CHANNELS-1:0]   full_on_reg, full_on_next;
    logic [CHANNELS-1:0]   lamp_reg, lamp_next;

    logic                  advance;
    logic                  flag_next;
    logic [DW-1:0]         set_delay;
    logic [mcpd_pkg::MASK_W+CHANNELS-1:0] en_ext;
    logic [mcpd_pkg::LAMP_W+CHANNELS-1:0] lamp_ext;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign en_ext   = {{CHANNELS{1'b0}}, in_item_reg.enable_mask};
    assign lamp_ext = {{mcpd_pkg::LAMP_W{1'b0}}, lamp_next};

    assign set_delay = (in_item_reg.brightness == mcpd_pkg::ZERO_BRIGHT) ? mcpd_pkg::PERIOD_END
                     : mcpd_pkg::PERIOD_END - {1'b0, in_item_reg.brightness, 1'b0};

    always_comb begin
        count_next   = count_reg;
        pending_next = pending_reg;
        latched_next = latched_reg;
        full_on_next = full_on_reg;
        lamp_next    = lamp_reg;
        flag_next    = 1'b0;
        if (in_item_reg.func == mcpd_pkg::FUNC_TICK) begin
            if (count_reg >= mcpd_pkg::PERIOD_END) begin
                count_next = '0;
            end else begin
                count_next = count_reg + DW'(1);
            end
            for (int c = 0; c < CHANNELS; c++) begin
                if (count_next == mcpd_pkg::PERIOD_END) begin
                    if (!full_on_reg[c]) begin
                        lamp_next[c] = 1'b0;
                    end
                    latched_next[c] = pending_reg[c];
                end else if (latched_reg[c] == count_next && en_ext[c]) begin
                    lamp_next[c] = 1'b1;
                end
            end
        end else begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (in_item_reg.channel == mcpd_pkg::CHAN_W'(c)) begin
                    if (in_item_reg.brightness == mcpd_pkg::FULL_BRIGHT) begin
                        full_on_next[c] = 1'b1;
                        pending_next[c] = mcpd_pkg::PERIOD_END;
                        if (en_ext[c]) begin
                            lamp_next[c] = 1'b1;
                        end
                    end else begin
                        full_on_next[c] = 1'b0;
                        pending_next[c] = set_delay;
                    end
                end
            end
        end
        for (int c = 0; c < CHANNELS; c++) begin
            if (in_item_reg.channel == mcpd_pkg::CHAN_W'(c)) begin
                flag_next = full_on_next[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            full_on_reg   <= '0;
            lamp_reg      <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                pending_reg[c] <= mcpd_pkg::PERIOD_END;
                latched_reg[c] <= mcpd_pkg::PERIOD_END;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
                pending_reg   <= pending_next;
                latched_reg   <= latched_next;
                full_on_reg   <= full_on_next;
                lamp_reg      <= lamp_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.func        <= mcpd_pkg::func_t'(s_tuser);
            in_item_reg.channel     <= s_tdata[7:0];
            in_item_reg.brightness  <= s_tdata[15:8];
            in_item_reg.enable_mask <= s_tdata[17:16];
        end
        if (advance) begin
            out_lamps_reg <= lamp_ext[mcpd_pkg::LAMP_W-1:0];
            out_flag_reg  <= flag_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mcpd_pkg::M_DATA_W - mcpd_pkg::LAMP_W - 1){1'b0}},
                       out_flag_reg, out_lamps_reg};

endmodule
